FILE: hdl/bsde_pkg.sv
//------------------------------------------------------------------------------
// bsde_pkg
// Types, constants and codes shared by the B-spline de Boor evaluator.
//------------------------------------------------------------------------------
package bsde_pkg;

	localparam int MAX_POINTS_DEF = 32;
	localparam int MAX_DEGREE_DEF = 10;

	localparam logic [1:0] CMD_POINT = 2'd0;
	localparam logic [1:0] CMD_KNOT  = 2'd1;
	localparam logic [1:0] CMD_EVAL  = 2'd2;

	localparam logic [1:0] REG_DEGREE = 2'd0;
	localparam logic [1:0] REG_COUNT  = 2'd1;

	localparam logic [3:0] DEGREE_RESET = 4'd3;

	typedef struct packed {
		logic [1:0]         command;
		logic [5:0]         entry_index;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] knot_value;
		logic signed [31:0] param_t;
	} bsde_in_t;

	typedef struct packed {
		logic               curve_valid;
		logic [3:0]         stage;
		logic [3:0]         position;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic               last;
	} bsde_out_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SRCH_HI,
		ST_SRCH_HI_W,
		ST_SRCH,
		ST_SRCH_W,
		ST_LOAD,
		ST_LOAD_W,
		ST_KLO,
		ST_KLO_W,
		ST_KHI,
		ST_KHI_W,
		ST_DIV,
		ST_MULX,
		ST_MULY,
		ST_EMIT,
		ST_OUT
	} bsde_state_t;

endpackage

FILE: hdl/bspline_de_boor_evaluator_unit.sv
//------------------------------------------------------------------------------
// bspline_de_boor_evaluator_unit
// B-spline evaluator by de Boor recursion in signed Q16.16.
//------------------------------------------------------------------------------
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall  | bsde_in_t
// out     | out | out_valid/out_stall| bsde_out_t
// cfg     | in  | APB write/read     | spline_degree, point_count
//
// An evaluation runs a binary search for the knot span, loads the d+1 control
// points, then computes each shell point with the shared radix-2 divider
// (49 steps) and one shared 33x32 multiplier; up to 55 points at degree 10.
// Reset clears control state; the stores are undefined until written.
// in_stall stays high while busy; a held result stalls only the sequencer.
//------------------------------------------------------------------------------
module bspline_de_boor_evaluator_unit
	import bsde_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  bsde_pkg::bsde_in_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output bsde_pkg::bsde_out_t  out_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int KDEPTH = MAX_POINTS + MAX_DEGREE + 1;
	localparam int PAW    = $clog2(MAX_POINTS);
	localparam int KAW    = $clog2(KDEPTH);
	localparam int SDEPTH = MAX_DEGREE + 1;
	localparam int SAW    = $clog2(SDEPTH);
	localparam int IW     = KAW + 1;
	localparam int DIVN   = 49;

	bsde_state_t state_q, state_d;

	logic [3:0] degree_q;
	logic [5:0] count_q;
	logic [3:0] d_eff;
	logic [IW-1:0] n_eff;

	logic signed [31:0] t_q;
	logic [IW-1:0] lo_q, hi_q, span_q, mid;
	logic [3:0] p_q, j_q;
	logic [IW-1:0] gi;
	logic signed [31:0] klo_q;
	logic signed [32:0] num_q;
	logic [49:0] rem_q;
	logic [48:0] dvd_q;
	logic [32:0] dvs_q;
	logic [48:0] quo_q;
	logic [5:0] cnt_q;
	logic neg_q;
	logic signed [31:0] alpha_q;
	logic signed [31:0] p0x_q, p0y_q, nx_q;
	logic signed [63:0] acc_q;
	bsde_out_t out_q;
	logic out_v_q;

	logic pt_we, kn_we, sc_we;
	logic [PAW-1:0] pt_waddr, pt_raddr;
	logic [KAW-1:0] kn_waddr, kn_raddr;
	logic [SAW-1:0] sc_waddr, sc_raddr;
	logic [63:0] pt_wdata, pt_rdata, sc_wdata, sc_rdata;
	logic [31:0] kn_rdata;

	logic in_acc, cfg_we;

	assign pready    = 1'b1;
	assign cfg_we    = psel & penable & pwrite;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid & ~in_stall;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			1'b0: prdata = {28'd0, degree_q};
			1'b1: prdata = {26'd0, count_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= DEGREE_RESET;
			count_q  <= '0;
		end else if (cfg_we && paddr[1:0] == 2'b00) begin
			if (paddr[2] == REG_DEGREE[0]) degree_q <= pwdata[3:0];
			else if (paddr[2] == REG_COUNT[0]) count_q <= pwdata[5:0];
		end
	end

	always_comb begin
		d_eff = degree_q;
		if (degree_q == 4'd0) d_eff = 4'd1;
		else if (32'(degree_q) > MAX_DEGREE) d_eff = 4'(MAX_DEGREE);
		n_eff = (32'(count_q) > MAX_POINTS) ? IW'(MAX_POINTS) : IW'(count_q);
	end

	assign mid = IW'((32'(lo_q) + 32'(hi_q)) >> 1);
	assign gi  = IW'(span_q - IW'(d_eff) + IW'(p_q) + IW'(j_q));

	bsde_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_pts (
		.clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
		.raddr(pt_raddr), .rdata(pt_rdata));
	bsde_ram #(.WIDTH(32), .DEPTH(KDEPTH)) u_knots (
		.clk(clk), .we(kn_we), .waddr(kn_waddr), .wdata(in_data.knot_value),
		.raddr(kn_raddr), .rdata(kn_rdata));
	bsde_ram #(.WIDTH(64), .DEPTH(SDEPTH)) u_shell (
		.clk(clk), .we(sc_we), .waddr(sc_waddr), .wdata(sc_wdata),
		.raddr(sc_raddr), .rdata(sc_rdata));

	assign pt_we    = in_acc && in_data.command == CMD_POINT
		&& 32'(in_data.entry_index) < MAX_POINTS;
	assign pt_waddr = PAW'(in_data.entry_index);
	assign pt_wdata = {in_data.point_x, in_data.point_y};
	assign kn_we    = in_acc && in_data.command == CMD_KNOT
		&& 32'(in_data.entry_index) < KDEPTH;
	assign kn_waddr = KAW'(in_data.entry_index);
	assign pt_raddr = PAW'(span_q - IW'(d_eff) + IW'(j_q));

	logic signed [32:0] sat_x;
	logic signed [64:0] rnd;
	logic signed [63:0] rnd_mag;
	logic signed [63:0] sum64;
	always_comb begin
		rnd_mag = acc_q[63] ? -acc_q : acc_q;
		rnd     = 65'((rnd_mag + 64'sd32768) >>> 16);
		sum64   = 64'(p0x_q) + (acc_q[63] ? -64'(rnd) : 64'(rnd));
		if (sum64 > 64'sd2147483647) sat_x = 33'sd2147483647;
		else if (sum64 < -64'sd2147483648) sat_x = -33'sd2147483648;
		else sat_x = 33'(sum64);
	end

	logic signed [32:0] mul_a;
	logic signed [64:0] mul_p;
	always_comb begin
		mul_a = (state_q == ST_MULX) ? 33'(nx_q) - 33'(p0x_q) : 33'(nx_q) - 33'(p0y_q);
		mul_p = mul_a * 65'(alpha_q);
	end

	always_comb begin
		sc_we    = 1'b0;
		sc_waddr = SAW'(j_q);
		sc_wdata = pt_rdata;
		sc_raddr = SAW'(j_q);
		kn_raddr = KAW'(hi_q);
		unique case (state_q)
			ST_SRCH_HI, ST_SRCH_HI_W: kn_raddr = KAW'(n_eff);
			ST_SRCH, ST_SRCH_W: kn_raddr = KAW'(mid);
			ST_LOAD_W: sc_we = 1'b1;
			ST_KLO, ST_KLO_W: kn_raddr = KAW'(gi);
			ST_KHI, ST_KHI_W: begin
				kn_raddr = KAW'(gi + IW'(d_eff) - IW'(p_q) + IW'(1));
				sc_raddr = SAW'(j_q + 4'd1);
			end
			ST_EMIT: begin
				sc_we    = 1'b1;
				sc_wdata = {out_q.out_x, sat_x[31:0]};
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc && in_data.command == CMD_EVAL) begin
				state_d = (n_eff <= IW'(d_eff)) ? ST_OUT : ST_SRCH_HI;
			end
			ST_SRCH_HI:   state_d = ST_SRCH_HI_W;
			ST_SRCH_HI_W: state_d = ST_SRCH;
			ST_SRCH:      state_d = (span_q != '0 || hi_q - lo_q <= IW'(1))
				? ST_LOAD : ST_SRCH_W;
			ST_SRCH_W:    state_d = ST_SRCH;
			ST_LOAD:      state_d = ST_LOAD_W;
			ST_LOAD_W:    state_d = (j_q == d_eff) ? ST_KLO : ST_LOAD;
			ST_KLO:       state_d = ST_KLO_W;
			ST_KLO_W:     state_d = ST_KHI;
			ST_KHI:       state_d = ST_KHI_W;
			ST_KHI_W:     state_d = ST_DIV;
			ST_DIV:       state_d = (cnt_q == '0) ? ST_MULX : ST_DIV;
			ST_MULX:      state_d = ST_MULY;
			ST_MULY:      state_d = ST_EMIT;
			ST_EMIT:      state_d = ST_OUT;
			ST_OUT: if (!out_v_q) begin
				state_d = ST_IDLE;
				if (out_q.curve_valid && !out_q.last) state_d = ST_KLO;
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EMIT || (state_q == ST_IDLE && in_acc
				&& in_data.command == CMD_EVAL && n_eff <= IW'(d_eff))) out_v_q <= 1'b1;
			else if (out_v_q && !out_stall) out_v_q <= 1'b0;
		end
	end

	logic [32:0] numa, dena;
	logic signed [32:0] den_nx;
	logic [49:0] rem_nx;
	always_comb begin
		den_nx = 33'($signed(kn_rdata)) - 33'(klo_q);
		numa   = num_q[32] ? 33'(-num_q) : 33'(num_q);
		dena   = den_nx[32] ? 33'(-den_nx) : 33'(den_nx);
		rem_nx = {rem_q[48:0], dvd_q[48]};
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				t_q <= in_data.param_t;
				lo_q <= IW'(d_eff);
				hi_q <= n_eff;
				span_q <= '0;
				j_q <= '0;
				p_q <= 4'd1;
				out_q <= '{curve_valid: 1'b0, stage: 4'd0, position: 4'd0,
					out_x: 32'sd0, out_y: 32'sd0, last: 1'b1};
			end
			ST_SRCH_HI_W: if (t_q >= $signed(kn_rdata)) span_q <= n_eff - IW'(1);
			ST_SRCH: if (span_q == '0 && hi_q - lo_q <= IW'(1)) span_q <= lo_q;
			ST_SRCH_W: begin
				if (t_q < $signed(kn_rdata)) hi_q <= mid;
				else lo_q <= mid;
			end
			ST_LOAD_W: begin
				if (j_q == d_eff) j_q <= '0;
				else j_q <= j_q + 4'd1;
			end
			ST_KLO_W: begin
				klo_q <= $signed(kn_rdata);
				num_q <= 33'(t_q) - 33'($signed(kn_rdata));
				p0x_q <= $signed(sc_rdata[63:32]);
				p0y_q <= $signed(sc_rdata[31:0]);
			end
			ST_KHI_W: begin
				nx_q  <= $signed(sc_rdata[63:32]);
				acc_q <= 64'($signed(sc_rdata[31:0]));
				dvd_q <= {numa, 16'd0};
				dvs_q <= dena;
				neg_q <= num_q[32] ^ den_nx[32];
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= 6'(DIVN - 1);
			end
			ST_DIV: begin
				dvd_q <= {dvd_q[47:0], 1'b0};
				if (rem_nx >= 50'(dvs_q)) begin
					rem_q <= rem_nx - 50'(dvs_q);
					quo_q <= {quo_q[47:0], 1'b1};
				end else begin
					rem_q <= rem_nx;
					quo_q <= {quo_q[47:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0) begin
					if (dvs_q == '0) alpha_q <= '0;
					else begin
						logic [48:0] qf;
						qf = {quo_q[47:0], (rem_nx >= 50'(dvs_q))};
						if (qf > 49'h40000000) qf = 49'h40000000;
						alpha_q <= neg_q ? -32'(qf) : 32'(qf);
					end
				end
			end
			ST_MULX: begin
				acc_q <= 64'(mul_p);
				nx_q  <= 32'(acc_q);
			end
			ST_MULY: begin
				out_q.out_x <= sat_x[31:0];
				acc_q <= 64'(mul_p);
				p0x_q <= p0y_q;
			end
			ST_EMIT: begin
				out_q.out_y <= sat_x[31:0];
				out_q.curve_valid <= 1'b1;
				out_q.stage <= p_q;
				out_q.position <= j_q;
				out_q.last <= (p_q == d_eff) && (j_q == d_eff - p_q);
			end
			ST_OUT: if (!out_v_q && out_q.curve_valid && !out_q.last) begin
				if (j_q == d_eff - p_q) begin
					j_q <= '0;
					p_q <= p_q + 4'd1;
				end else j_q <= j_q + 4'd1;
			end
			default: ;
		endcase
	end

endmodule

FILE: hdl/bsde_ram.sv
//------------------------------------------------------------------------------
// bsde_ram
// Single-port write, single-port read RAM with registered read data.
//------------------------------------------------------------------------------
module bsde_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/bsde_checker.sv
//------------------------------------------------------------------------------
// bsde_checker
// Port-level checks for the B-spline de Boor evaluator.
//------------------------------------------------------------------------------
module bsde_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input bsde_pkg::bsde_out_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");

	a_invalid_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.curve_valid |-> out_data.last)
		else $error("invalid result not last");

	a_stage_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.curve_valid |-> out_data.stage != 4'd0)
		else $error("valid result with stage zero");

endmodule

bind bspline_de_boor_evaluator_unit bsde_checker u_bsde_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));
